// ----- src/msc_pkg.sv -----
`timescale 1ns / 1ps

package msc_pkg;

    // configuration register map
    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_PCM_SHIFT      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WARMUP         = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DEAD_START     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RAW_PEAK_THR   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_RAW_DELTA_THR  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_PCM_PEAK_THR   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_DEAD_LIMIT     = 3'd6;

    localparam logic [4:0]  RST_PCM_SHIFT     = 5'd14;
    localparam logic [31:0] RST_WARMUP        = 32'd48000;
    localparam logic [31:0] RST_DEAD_START    = 32'd80000;
    localparam logic [30:0] RST_RAW_PEAK_THR  = 31'd1000;
    localparam logic [30:0] RST_RAW_DELTA_THR = 31'd500;
    localparam logic [15:0] RST_PCM_PEAK_THR  = 16'd20;
    localparam logic [7:0]  RST_DEAD_LIMIT    = 8'd20;

    // shift used when the register holds zero
    localparam logic [4:0]  DEFAULT_SHIFT     = 5'd14;

    localparam logic signed [15:0] PCM_MAX = 16'sh7FFF;
    localparam logic signed [15:0] PCM_MIN = -16'sh8000;

    typedef struct packed {
        logic [4:0]  pcm_shift_amount;
        logic [31:0] warmup_samples;
        logic [31:0] dead_start_samples;
        logic [30:0] raw_peak_threshold;
        logic [30:0] raw_delta_threshold;
        logic [15:0] pcm_peak_threshold;
        logic [7:0]  dead_block_limit;
    } msc_cfg_t;

    typedef struct packed {
        logic signed [31:0] raw_sample;
        logic               block_last;
    } msc_in_t;

    typedef struct packed {
        logic signed [15:0] pcm_sample;
        logic               block_done;
        logic [15:0]        block_peak;
        logic signed [15:0] block_min;
        logic signed [15:0] block_max;
        logic [15:0]        block_rms;
        logic [30:0]        raw_abs_peak;
        logic               mic_valid;
        logic               dead_alert;
    } msc_out_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic dc_upd;
        logic y_calc;
        logic acc;
        logic sum;
        logic div_init;
        logic div_step;
        logic sqrt_init;
        logic sqrt_step;
        logic fin1;
        logic fin2;
        logic emit;
    } msc_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic blk_end;
        logic div_last;
        logic sqrt_last;
        logic out_free;
    } msc_sts_t;

endpackage

// ----- src/msc_cfg.sv -----
`timescale 1ns / 1ps

module msc_cfg (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [msc_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [31:0]                         cfg_data,
    output msc_pkg::msc_cfg_t                   cfg
);
    import msc_pkg::*;

    msc_cfg_t cfg_reg;
    msc_cfg_t cfg_next;
    logic     wr;

    // the user must keep writes to idle time, and the block leaves that unenforced; the port never backs up
    assign cfg_ready = 1'b1;
    assign wr        = cfg_valid && cfg_ready;
    assign cfg       = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr)
        begin
            unique case (cfg_index)
                CFG_PCM_SHIFT:     cfg_next.pcm_shift_amount    = cfg_data[4:0];
                CFG_WARMUP:        cfg_next.warmup_samples      = cfg_data;
                CFG_DEAD_START:    cfg_next.dead_start_samples  = cfg_data;
                CFG_RAW_PEAK_THR:  cfg_next.raw_peak_threshold  = cfg_data[30:0];
                CFG_RAW_DELTA_THR: cfg_next.raw_delta_threshold = cfg_data[30:0];
                CFG_PCM_PEAK_THR:  cfg_next.pcm_peak_threshold  = cfg_data[15:0];
                CFG_DEAD_LIMIT:    cfg_next.dead_block_limit    = cfg_data[7:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.pcm_shift_amount    <= RST_PCM_SHIFT;
            cfg_reg.warmup_samples      <= RST_WARMUP;
            cfg_reg.dead_start_samples  <= RST_DEAD_START;
            cfg_reg.raw_peak_threshold  <= RST_RAW_PEAK_THR;
            cfg_reg.raw_delta_threshold <= RST_RAW_DELTA_THR;
            cfg_reg.pcm_peak_threshold  <= RST_PCM_PEAK_THR;
            cfg_reg.dead_block_limit    <= RST_DEAD_LIMIT;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ----- src/msc_ctrl.sv -----
`timescale 1ns / 1ps

module msc_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  msc_pkg::msc_sts_t  sts,
    output msc_pkg::msc_cmd_t  cmd
);
    import msc_pkg::*;

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_DC    = 4'd1;
    localparam logic [3:0] ST_YC    = 4'd2;
    localparam logic [3:0] ST_ACC   = 4'd3;
    localparam logic [3:0] ST_SUM   = 4'd4;
    localparam logic [3:0] ST_DINIT = 4'd5;
    localparam logic [3:0] ST_DIV   = 4'd6;
    localparam logic [3:0] ST_SINIT = 4'd7;
    localparam logic [3:0] ST_SQRT  = 4'd8;
    localparam logic [3:0] ST_FIN1  = 4'd9;
    localparam logic [3:0] ST_FIN2  = 4'd10;
    localparam logic [3:0] ST_EMIT  = 4'd11;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    assign in_stall = (state_reg != ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_DC;
                end
            end
            ST_DC:
            begin
                cmd.dc_upd = 1'b1;
                state_next = ST_YC;
            end
            ST_YC:
            begin
                cmd.y_calc = 1'b1;
                state_next = ST_ACC;
            end
            ST_ACC:
            begin
                cmd.acc    = 1'b1;
                state_next = ST_SUM;
            end
            ST_SUM:
            begin
                cmd.sum    = 1'b1;
                state_next = sts.blk_end ? ST_DINIT : ST_EMIT;
            end
            ST_DINIT:
            begin
                cmd.div_init = 1'b1;
                state_next   = ST_DIV;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (sts.div_last)
                begin
                    state_next = ST_SINIT;
                end
            end
            ST_SINIT:
            begin
                cmd.sqrt_init = 1'b1;
                state_next    = ST_SQRT;
            end
            ST_SQRT:
            begin
                cmd.sqrt_step = 1'b1;
                if (sts.sqrt_last)
                begin
                    state_next = ST_FIN1;
                end
            end
            ST_FIN1:
            begin
                cmd.fin1   = 1'b1;
                state_next = ST_FIN2;
            end
            ST_FIN2:
            begin
                cmd.fin2   = 1'b1;
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (sts.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ----- src/msc_dp.sv -----
`timescale 1ns / 1ps

module msc_dp #(
    parameter int BLOCK_MAX = 512
) (
    input  logic               clk,
    input  logic               rst_n,
    input  msc_pkg::msc_cfg_t  cfg,
    input  msc_pkg::msc_in_t   in_data,
    input  msc_pkg::msc_cmd_t  cmd,
    output msc_pkg::msc_sts_t  sts,
    input  logic               out_stall,
    output logic               out_valid,
    output msc_pkg::msc_out_t  out_data
);
    import msc_pkg::*;

    localparam int CNT_W = $clog2(BLOCK_MAX + 1);
    localparam int SUM_W = 30 + CNT_W;
    localparam int IT_W  = $clog2(SUM_W);

    localparam logic [CNT_W-1:0] BLK_LIM  = CNT_W'(BLOCK_MAX);
    localparam logic [IT_W-1:0]  DIV_LAST = IT_W'(SUM_W - 1);

    function automatic logic [30:0] absdiff(input logic [30:0] a, input logic [30:0] b);
        absdiff = (a > b) ? (a - b) : (b - a);
    endfunction

    // per-item working registers
    logic signed [15:0] x_reg;
    logic [30:0]        rabs_reg;
    logic               last_reg;
    logic signed [15:0] y_reg;
    logic [31:0]        sq_reg;
    logic               end_reg;

    // architectural state
    logic signed [33:0] dc_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic [SUM_W-1:0]   sum_reg;
    logic [15:0]        run_peak_reg;
    logic signed [15:0] run_min_reg;
    logic signed [15:0] run_max_reg;
    logic [30:0]        run_raw_reg;
    logic [30:0]        hist0_reg;
    logic [30:0]        hist1_reg;
    logic [31:0]        total_reg;
    logic               flag_reg;
    logic [7:0]         dead_reg;

    // block-end registers
    logic               varying_reg;
    logic               pcm_ok_reg;
    logic               alert_reg;

    // divider and square root
    logic [SUM_W-1:0]   quo_reg;
    logic [CNT_W-1:0]   rem_reg;
    logic [IT_W-1:0]    div_it_reg;
    logic [31:0]        n_reg;
    logic [31:0]        res_reg;
    logic [31:0]        bit_reg;

    logic               out_valid_reg;
    msc_out_t           out_data_reg;

    // input conditioning
    logic [4:0]         sh;
    logic signed [31:0] shifted;
    logic [30:0]        raw_abs;

    assign sh      = (cfg.pcm_shift_amount == 5'd0) ? DEFAULT_SHIFT : cfg.pcm_shift_amount;
    assign shifted = $signed(in_data.raw_sample) >>> sh;

    always_comb
    begin
        if (!in_data.raw_sample[31])
        begin
            raw_abs = in_data.raw_sample[30:0];
        end
        else if (in_data.raw_sample[30:0] == 31'd0)
        begin
            raw_abs = '1;
        end
        else
        begin
            raw_abs = 31'(-in_data.raw_sample);
        end
    end

    // dc blocker, q16
    logic signed [33:0] xq;
    logic signed [34:0] d;
    logic signed [43:0] pd;
    logic signed [43:0] p;
    logic signed [33:0] dc_inc;
    logic signed [34:0] vadj;
    logic signed [18:0] q;
    logic signed [15:0] y_sat;

    assign xq     = {{2{x_reg[15]}}, x_reg, 16'd0};
    assign d      = {xq[33], xq} - {dc_reg[33], dc_reg};
    assign pd     = {{9{d[34]}}, d};
    // times 328 = 256 + 64 + 8
    assign p      = (pd <<< 8) + (pd <<< 6) + (pd <<< 3);
    assign dc_inc = {{6{p[43]}}, p[43:16]};
    // truncate toward zero
    assign vadj   = d[34] ? (d + 35'sd65535) : d;
    assign q      = vadj[34:16];

    always_comb
    begin
        if (q > 19'sd32767)
        begin
            y_sat = PCM_MAX;
        end
        else if (q < -19'sd32768)
        begin
            y_sat = PCM_MIN;
        end
        else
        begin
            y_sat = q[15:0];
        end
    end

    logic [15:0] ay;
    assign ay = y_reg[15] ? 16'(-y_reg) : 16'(y_reg);

    // restoring divider step
    logic [CNT_W:0]   trial;
    logic [CNT_W:0]   trial_diff;
    logic             trial_ge;
    logic [CNT_W-1:0] rem_next;

    assign trial      = {rem_reg, quo_reg[SUM_W-1]};
    assign trial_diff = trial - {1'b0, cnt_reg};
    assign trial_ge   = (trial >= {1'b0, cnt_reg});
    assign rem_next   = trial_ge ? trial_diff[CNT_W-1:0] : trial[CNT_W-1:0];

    // square root step
    logic [31:0] sq_t;
    logic        sq_ge;

    assign sq_t  = res_reg + bit_reg;
    assign sq_ge = (n_reg >= sq_t);

    // block-end decisions
    logic [32:0] total_sum;
    logic [31:0] total_next;
    logic        varying;
    logic        flag_next;
    logic [7:0]  dead_inc;

    assign total_sum  = {1'b0, total_reg} + 33'(cnt_reg);
    assign total_next = total_sum[32] ? 32'hFFFF_FFFF : total_sum[31:0];

    // history after the shift: run_raw_reg, hist0_reg, hist1_reg
    assign varying = (run_raw_reg > cfg.raw_peak_threshold) ||
                     ((run_raw_reg != 31'd0) && (hist0_reg != 31'd0) && (hist1_reg != 31'd0) &&
                      ((absdiff(run_raw_reg, hist1_reg) > cfg.raw_delta_threshold) ||
                       (absdiff(hist0_reg, hist1_reg) > cfg.raw_delta_threshold)));

    assign flag_next = (total_reg > cfg.warmup_samples) ? (varying_reg && pcm_ok_reg) : flag_reg;
    assign dead_inc  = dead_reg + 8'd1;

    assign sts.blk_end   = last_reg || (cnt_reg >= BLK_LIM);
    assign sts.div_last  = (div_it_reg == DIV_LAST);
    assign sts.sqrt_last = bit_reg[0];
    assign sts.out_free  = !out_valid_reg || !out_stall;

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // working registers, no reset
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            x_reg    <= shifted[15:0];
            rabs_reg <= raw_abs;
            last_reg <= in_data.block_last;
        end
        if (cmd.y_calc)
        begin
            y_reg <= y_sat;
        end
        if (cmd.acc)
        begin
            sq_reg <= ay * ay;
        end
        if (cmd.sum)
        begin
            end_reg <= sts.blk_end;
        end
        if (cmd.div_init)
        begin
            quo_reg    <= sum_reg;
            rem_reg    <= '0;
            div_it_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            quo_reg    <= {quo_reg[SUM_W-2:0], trial_ge};
            rem_reg    <= rem_next;
            div_it_reg <= div_it_reg + IT_W'(1);
        end
        if (cmd.sqrt_init)
        begin
            // quotient never exceeds 2^30
            n_reg   <= {1'b0, quo_reg[30:0]};
            res_reg <= '0;
            bit_reg <= 32'h4000_0000;
        end
        else if (cmd.sqrt_step)
        begin
            if (sq_ge)
            begin
                n_reg   <= n_reg - sq_t;
                res_reg <= (res_reg >> 1) + bit_reg;
            end
            else
            begin
                res_reg <= res_reg >> 1;
            end
            bit_reg <= bit_reg >> 2;
        end
        if (cmd.fin1)
        begin
            varying_reg <= varying;
            pcm_ok_reg  <= (run_peak_reg > cfg.pcm_peak_threshold);
        end
        if (cmd.fin2)
        begin
            alert_reg <= 1'b0;
            if (!flag_next && (total_reg > cfg.dead_start_samples) && (dead_reg != 8'hFF))
            begin
                alert_reg <= (dead_inc == cfg.dead_block_limit);
            end
        end
        if (cmd.emit)
        begin
            out_data_reg.pcm_sample <= y_reg;
            out_data_reg.block_done <= end_reg;
            out_data_reg.mic_valid  <= flag_reg;
            if (end_reg)
            begin
                out_data_reg.block_peak   <= run_peak_reg;
                out_data_reg.block_min    <= run_min_reg;
                out_data_reg.block_max    <= run_max_reg;
                out_data_reg.block_rms    <= res_reg[15:0];
                out_data_reg.raw_abs_peak <= run_raw_reg;
                out_data_reg.dead_alert   <= alert_reg;
            end
            else
            begin
                out_data_reg.block_peak   <= '0;
                out_data_reg.block_min    <= '0;
                out_data_reg.block_max    <= '0;
                out_data_reg.block_rms    <= '0;
                out_data_reg.raw_abs_peak <= '0;
                out_data_reg.dead_alert   <= 1'b0;
            end
        end
    end

    // state carried across items
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dc_reg        <= '0;
            cnt_reg       <= '0;
            sum_reg       <= '0;
            run_peak_reg  <= '0;
            run_min_reg   <= PCM_MAX;
            run_max_reg   <= PCM_MIN;
            run_raw_reg   <= '0;
            hist0_reg     <= '0;
            hist1_reg     <= '0;
            total_reg     <= '0;
            flag_reg      <= 1'b0;
            dead_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.dc_upd)
            begin
                dc_reg <= dc_reg + dc_inc;
            end
            if (cmd.acc)
            begin
                if (ay > run_peak_reg)
                begin
                    run_peak_reg <= ay;
                end
                if (y_reg < run_min_reg)
                begin
                    run_min_reg <= y_reg;
                end
                if (y_reg > run_max_reg)
                begin
                    run_max_reg <= y_reg;
                end
                if (rabs_reg > run_raw_reg)
                begin
                    run_raw_reg <= rabs_reg;
                end
                cnt_reg <= cnt_reg + CNT_W'(1);
            end
            if (cmd.sum)
            begin
                sum_reg <= sum_reg + SUM_W'(sq_reg);
            end
            if (cmd.fin1)
            begin
                // the oldest entry drops out, only two need keeping
                hist1_reg <= hist0_reg;
                hist0_reg <= run_raw_reg;
                total_reg <= total_next;
            end
            if (cmd.fin2)
            begin
                flag_reg <= flag_next;
                if (!flag_next && (total_reg > cfg.dead_start_samples))
                begin
                    if (dead_reg != 8'hFF)
                    begin
                        dead_reg <= dead_inc;
                    end
                end
                else
                begin
                    dead_reg <= '0;
                end
            end
            if (cmd.emit && end_reg)
            begin
                cnt_reg      <= '0;
                sum_reg      <= '0;
                run_peak_reg <= '0;
                run_min_reg  <= PCM_MAX;
                run_max_reg  <= PCM_MIN;
                run_raw_reg  <= '0;
            end
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule

// ----- src/mic_sample_conditioner_stats.sv -----
`timescale 1ns / 1ps

// microphone sample conditioner with block statistics. each input transfer carries one
// left-aligned 32-bit slot word and a block-last mark; each one yields exactly one output
// transfer with the dc-blocked, saturated 16-bit pcm sample, the current mic-valid flag and,
// on the last sample of a block (or the sample that fills BLOCK_MAX), the block peak, min,
// max, rms, raw absolute peak and the dead-block alert. an ordinary sample goes from input
// transfer to result through the dc update, saturation, square and accumulate steps of the
// datapath. a block-end sample also passes the restoring mean-square divider, one quotient
// bit per cycle, then 16 square-root steps and the fin1 and fin2 steps of flag and dead-count
// update. a result waiting in the output register does not hold off the next input transfer.
// configuration registers are written through the cfg port, index per the register list, and
// must only be written while no sample is in flight.
module mic_sample_conditioner_stats #(
    parameter int BLOCK_MAX = 512
) (
    input  logic                           clk,
    input  logic                           rst_n,
    // sample input
    input  logic                           in_valid,
    output logic                           in_stall,
    input  msc_pkg::msc_in_t               in_data,
    // result output
    output logic                           out_valid,
    input  logic                           out_stall,
    output msc_pkg::msc_out_t              out_data,
    // configuration write
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [msc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [31:0]                    cfg_data
);
    import msc_pkg::*;

    msc_cfg_t cfg;
    msc_cmd_t cmd;
    msc_sts_t sts;

    // register file, reset to the documented defaults
    msc_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // sequencer: one sample at a time, long path only on block end
    msc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    // dc blocker, running stats, divider, square root, output register
    msc_dp #(
        .BLOCK_MAX (BLOCK_MAX)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_data   (in_data),
        .cmd       (cmd),
        .sts       (sts),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .out_data  (out_data)
    );

endmodule

// ----- verif/tb.sv -----
`timescale 1ns / 1ps

module tb;

    import msc_pkg::*;

    localparam int BLOCK_LEN      = 512;   // forced block end, also the dut parameter
    localparam int DEAD_COUNT_MAX = 255;   // dead-block counter saturates here
    localparam int SETTLE_CYCLES  = 100;   // longer than the block-end path
    localparam int WATCHDOG_LIMIT = 5000;  // cycles without any transfer
    localparam int REPORT_LIMIT   = 10;
    localparam int PHASE_ITEMS    = 200;

    // directed corner samples, {block_last, raw_sample}
    localparam logic [32:0] CORNER_ITEMS [18] = '{
        {1'b0, 32'h0000_0000},   // zero
        {1'b0, 32'h7FFF_FFFF},   // raw max, shifted value wraps to -1
        {1'b0, 32'h8000_0000},   // raw min, absolute value saturates
        {1'b0, 32'hFFFF_FFFF},
        {1'b1, 32'h8000_0001},
        {1'b1, 32'h1FFF_C000},   // pcm max, single-sample block
        {1'b0, 32'hE000_0000},   // pcm min pulls the dc estimate down
        {1'b0, 32'hE000_0000},
        {1'b0, 32'hE000_0000},
        {1'b1, 32'h1FFF_C000},   // jump up saturates the output high
        {1'b0, 32'h1FFF_C000},
        {1'b0, 32'h1FFF_C000},
        {1'b1, 32'hE000_0000},   // jump down saturates low, peak of 32768
        {1'b0, 32'h0000_4000},
        {1'b0, 32'hFFFF_C000},
        {1'b0, 32'h5555_5555},
        {1'b1, 32'hAAAA_AAAA},
        {1'b1, 32'h0000_0000}
    };

    // signal shapes used for random capture blocks
    typedef enum int {SILENT, QUIET, LOUD, NOISE, RAILS} tone_kind_e;

    // ------------------------------------------------------------------
    // predictor of the conditioner plus the store of results still due
    // ------------------------------------------------------------------
    class pcm_stats_scoreboard;

        msc_out_t pending_results[$];

        // register copies
        logic [4:0]  shift_cfg;
        logic [31:0] warmup_cfg;
        logic [31:0] dead_start_cfg;
        logic [30:0] raw_thr_cfg;
        logic [30:0] delta_thr_cfg;
        logic [15:0] pcm_thr_cfg;
        logic [7:0]  dead_limit_cfg;

        // conditioner state
        longint          dc_level;      // dc estimate in q16
        int unsigned     n_in_block;
        longint unsigned energy;        // sum of squares over the block
        int              peak_mag;
        int              low_pcm;
        int              high_pcm;
        logic [30:0]     raw_peak;
        logic [30:0]     raw_peak_hist[3];
        logic [31:0]     samples_seen;  // saturating total
        bit              mic_ok;
        int unsigned     dead_run;

        // run statistics
        int failures;
        int samples_noted;
        int block_ends;
        int alerts;
        int valid_results;

        function new();
            shift_cfg      = RST_PCM_SHIFT;
            warmup_cfg     = RST_WARMUP;
            dead_start_cfg = RST_DEAD_START;
            raw_thr_cfg    = RST_RAW_PEAK_THR;
            delta_thr_cfg  = RST_RAW_DELTA_THR;
            pcm_thr_cfg    = RST_PCM_PEAK_THR;
            dead_limit_cfg = RST_DEAD_LIMIT;
            dc_level       = 0;
            samples_seen   = '0;
            mic_ok         = 1'b0;
            dead_run       = 0;
            raw_peak_hist  = '{default: '0};
            clear_block();
        endfunction

        function void clear_block();
            n_in_block = 0;
            energy     = 0;
            peak_mag   = 0;
            low_pcm    = PCM_MAX;
            high_pcm   = PCM_MIN;
            raw_peak   = '0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] value);
            case (idx)
                CFG_PCM_SHIFT:     shift_cfg      = value[4:0];
                CFG_WARMUP:        warmup_cfg     = value;
                CFG_DEAD_START:    dead_start_cfg = value;
                CFG_RAW_PEAK_THR:  raw_thr_cfg    = value[30:0];
                CFG_RAW_DELTA_THR: delta_thr_cfg  = value[30:0];
                CFG_PCM_PEAK_THR:  pcm_thr_cfg    = value[15:0];
                CFG_DEAD_LIMIT:    dead_limit_cfg = value[7:0];
                default: ;
            endcase
        endfunction

        // floor of the square root, one result bit at a time
        function int unsigned floor_root(longint unsigned n);
            int unsigned     r = 0;
            longint unsigned c;
            for (int b = 15; b >= 0; b--)
            begin
                c = r | (1 << b);
                if (c * c <= n)
                    r = c;
            end
            return r;
        endfunction

        function logic [30:0] spread(logic [30:0] a, logic [30:0] b);
            return (a > b) ? a - b : b - a;
        endfunction

        function void note_sample(msc_in_t s);
            logic signed [31:0] raw;
            logic signed [31:0] shifted;
            logic signed [15:0] x;
            logic signed [15:0] y;
            logic [4:0]         sh;
            logic [30:0]        raw_mag;
            longint             xq;
            longint             yq;
            int                 yi;
            int                 mag;
            bit                 moving;
            bit                 pcm_ok;
            bit                 alert;
            msc_out_t           want;

            raw = s.raw_sample;
            sh  = (shift_cfg == '0) ? DEFAULT_SHIFT : shift_cfg;
            shifted = raw >>> sh;
            x = shifted[15:0];   // keep low 16 bits, wraps

            if (raw == 32'h8000_0000)
                raw_mag = '1;
            else if (raw < 0)
                raw_mag = 31'(-raw);
            else
                raw_mag = raw[30:0];

            // dc blocker, estimate update floors, output truncates toward zero
            xq = longint'(x) * 65536;
            dc_level = dc_level + (((xq - dc_level) * 328) >>> 16);
            yq = (xq - dc_level) / 65536;
            if (yq > PCM_MAX)
                y = PCM_MAX;
            else if (yq < PCM_MIN)
                y = PCM_MIN;
            else
                y = 16'(yq);

            yi  = y;
            mag = (yi < 0) ? -yi : yi;
            if (mag > peak_mag)
                peak_mag = mag;
            if (yi < low_pcm)
                low_pcm = yi;
            if (yi > high_pcm)
                high_pcm = yi;
            energy += longint'(mag) * mag;
            if (raw_mag > raw_peak)
                raw_peak = raw_mag;
            n_in_block++;

            want = '0;
            want.pcm_sample = y;

            if (s.block_last || n_in_block >= BLOCK_LEN)
            begin
                raw_peak_hist[2] = raw_peak_hist[1];
                raw_peak_hist[1] = raw_peak_hist[0];
                raw_peak_hist[0] = raw_peak;

                moving = (raw_peak > raw_thr_cfg) ||
                         (raw_peak_hist[0] != 0 && raw_peak_hist[1] != 0 &&
                          raw_peak_hist[2] != 0 &&
                          (spread(raw_peak_hist[0], raw_peak_hist[2]) > delta_thr_cfg ||
                           spread(raw_peak_hist[1], raw_peak_hist[2]) > delta_thr_cfg));
                pcm_ok = peak_mag > pcm_thr_cfg;

                if (32'hFFFF_FFFF - samples_seen < n_in_block)
                    samples_seen = '1;
                else
                    samples_seen += n_in_block;

                if (samples_seen > warmup_cfg)
                    mic_ok = moving && pcm_ok;

                // dead counting fires the alert only on the step that hits the limit
                alert = 1'b0;
                if (!mic_ok && samples_seen > dead_start_cfg)
                begin
                    if (dead_run < DEAD_COUNT_MAX)
                    begin
                        dead_run++;
                        alert = (dead_run == dead_limit_cfg);
                    end
                end
                else
                    dead_run = 0;

                want.block_done   = 1'b1;
                want.block_peak   = 16'(peak_mag);
                want.block_min    = 16'(low_pcm);
                want.block_max    = 16'(high_pcm);
                want.block_rms    = 16'(floor_root(energy / n_in_block));
                want.raw_abs_peak = raw_peak;
                want.dead_alert   = alert;
                block_ends++;
                if (alert)
                    alerts++;
                clear_block();
            end

            want.mic_valid = mic_ok;
            if (mic_ok)
                valid_results++;
            samples_noted++;
            pending_results.push_back(want);
        endfunction

        function string show(msc_out_t r);
            return $sformatf("pcm=%0d done=%0b peak=%0d min=%0d max=%0d rms=%0d raw=%0d valid=%0b alert=%0b",
                             $signed(r.pcm_sample), r.block_done, r.block_peak,
                             $signed(r.block_min), $signed(r.block_max), r.block_rms,
                             r.raw_abs_peak, r.mic_valid, r.dead_alert);
        endfunction

        function void flag_mismatch(string msg);
            failures++;
            if (failures <= REPORT_LIMIT)
                $display("[%0t] mismatch: %s", $realtime, msg);
        endfunction

        function void check_result(msc_out_t got);
            msc_out_t want;
            string    bad = "";
            if (pending_results.size() == 0)
            begin
                flag_mismatch($sformatf("result with nothing due: %s", show(got)));
                return;
            end
            want = pending_results.pop_front();
            if (got.pcm_sample   !== want.pcm_sample)   bad = {bad, " pcm_sample"};
            if (got.block_done   !== want.block_done)   bad = {bad, " block_done"};
            if (got.block_peak   !== want.block_peak)   bad = {bad, " block_peak"};
            if (got.block_min    !== want.block_min)    bad = {bad, " block_min"};
            if (got.block_max    !== want.block_max)    bad = {bad, " block_max"};
            if (got.block_rms    !== want.block_rms)    bad = {bad, " block_rms"};
            if (got.raw_abs_peak !== want.raw_abs_peak) bad = {bad, " raw_abs_peak"};
            if (got.mic_valid    !== want.mic_valid)    bad = {bad, " mic_valid"};
            if (got.dead_alert   !== want.dead_alert)   bad = {bad, " dead_alert"};
            if (bad != "")
                flag_mismatch($sformatf("fields%s\n  expected %s\n  actual   %s",
                                        bad, show(want), show(got)));
        endfunction

    endclass

    // ------------------------------------------------------------------
    // clock, reset and dut
    // ------------------------------------------------------------------
    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 in_valid  = 1'b0;
    logic                 in_stall;
    msc_in_t              in_data   = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    msc_out_t             out_data;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [31:0]          cfg_data  = '0;

    pcm_stats_scoreboard sb = new();

    int send_idle_pct = 0;   // chance per transfer that the sample source pauses
    int recv_idle_pct = 0;   // chance per cycle that the sink stalls
    int idle_cycles   = 0;   // cycles since the last transfer on any port
    int settings_used = 0;

    initial
    begin
        forever #5 clk = ~clk;
    end

    mic_sample_conditioner_stats #(
        .BLOCK_MAX (BLOCK_LEN)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // sink side: random stall, fresh decision each cycle
    always @(posedge clk)
    begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    // result monitor, values seen here are the ones sampled at this edge
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_result(out_data);
    end

    // watchdog on lack of progress
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
            (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog: no transfer for %0d cycles, %0d results still due",
                     idle_cycles, sb.pending_results.size());
            $display("tb: failure");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // drivers
    // ------------------------------------------------------------------

    // cfg_valid is left high so that back-to-back writes never drop it
    task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [31:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        sb.write_reg(idx, value);
    endtask

    task automatic program_settings(logic [4:0] shift, logic [31:0] warmup,
                                    logic [31:0] dead_start, logic [30:0] raw_thr,
                                    logic [30:0] delta_thr, logic [15:0] pcm_thr,
                                    logic [7:0] dead_limit);
        write_register(CFG_PCM_SHIFT,     32'(shift));
        write_register(CFG_WARMUP,        warmup);
        write_register(CFG_DEAD_START,    dead_start);
        write_register(CFG_RAW_PEAK_THR,  32'(raw_thr));
        write_register(CFG_RAW_DELTA_THR, 32'(delta_thr));
        write_register(CFG_PCM_PEAK_THR,  32'(pcm_thr));
        write_register(CFG_DEAD_LIMIT,    32'(dead_limit));
        cfg_valid <= 1'b0;
        settings_used++;
    endtask

    // one sample transfer, with an optional random pause in front of it
    task automatic send_sample(logic signed [31:0] raw, bit last);
        msc_in_t item;
        item.raw_sample = raw;
        item.block_last = last;
        if ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < send_idle_pct)
                @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.note_sample(item);
    endtask

    // one capture block of a random shape, last sample marked
    task automatic send_block(int len);
        tone_kind_e         kind;
        int                 span;
        int                 offset;
        int                 amp;
        logic signed [31:0] raw;
        kind = tone_kind_e'($urandom_range(RAILS));
        span = 1 << ((kind == LOUD) ? $urandom_range(0, 28) : $urandom_range(0, 10));
        offset = int'($urandom_range(0, 2 * span)) - span;
        amp = 1 << ((kind == QUIET) ? $urandom_range(0, 12) : $urandom_range(13, 29));
        for (int i = 0; i < len; i++)
        begin
            case (kind)
                SILENT: raw = int'($urandom_range(0, 2)) - 1;
                QUIET, LOUD: raw = offset + int'($urandom_range(0, 2 * amp)) - amp;
                NOISE: raw = $urandom;
                default:
                begin
                    case ($urandom_range(3))
                        0: raw = 32'h7FFF_FFFF;
                        1: raw = 32'h8000_0000;
                        2: raw = 32'h0000_0000;
                        default: raw = 32'hFFFF_FFFF;
                    endcase
                end
            endcase
            send_sample(raw, i == len - 1);
        end
    endtask

    // mostly short blocks, some medium and a few longer ones, or only single-sample blocks when single is set
    task automatic run_blocks(int target, bit single);
        int sent = 0;
        int len;
        int r;
        while (sent < target)
        begin
            r = $urandom_range(99);
            if (single || r < 30)
                len = 1;
            else if (r < 70)
                len = $urandom_range(2, 8);
            else if (r < 93)
                len = $urandom_range(9, 64);
            else
                len = $urandom_range(65, 200);
            send_block(len);
            sent += len;
        end
    endtask

    // let every result arrive, then give the block time to go quiet
    task automatic drain_results();
        in_valid <= 1'b0;
        while (sb.pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // test sequence
    // ------------------------------------------------------------------
    initial
    begin
        repeat (2)
            @(posedge clk);
        rst_n <= 1'b1;

        // slow sink first
        send_idle_pct = 9;
        recv_idle_pct = 81;

        // corner samples under the reset register values
        foreach (CORNER_ITEMS[i])
            send_sample(CORNER_ITEMS[i][31:0], CORNER_ITEMS[i][32]);
        drain_results();

        // reset thresholds, short warmup so flag and dead count move
        program_settings(RST_PCM_SHIFT, 32'($urandom_range(0, 200)),
                         32'($urandom_range(0, 200)), RST_RAW_PEAK_THR,
                         RST_RAW_DELTA_THR, RST_PCM_PEAK_THR, 8'($urandom_range(1, 8)));
        run_blocks(PHASE_ITEMS, 1'b0);
        drain_results();

        // every register at its top value but the pcm threshold at 0x8000, flag and dead count frozen
        program_settings(5'd31, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 31'h7FFF_FFFF,
                         31'h7FFF_FFFF, 16'h8000, 8'd255);
        run_blocks(PHASE_ITEMS, 1'b0);
        drain_results();

        // slow source now
        send_idle_pct = 81;
        recv_idle_pct = 9;

        // bottom values: zero shift means default shift, alert on first dead block
        program_settings(5'd0, 32'd0, 32'd0, 31'd0, 31'd0, 16'd0, 8'd1);
        // block runs past the maximum length before its last mark
        send_block(BLOCK_LEN + $urandom_range(1, 40));
        run_blocks(PHASE_ITEMS, 1'b0);
        drain_results();

        // pcm threshold out of reach: every block dead, counter saturates
        program_settings(5'd16, 32'd0, 32'd0, 31'h7FFF_FFFF, 31'h7FFF_FFFF,
                         16'h8000, 8'd255);
        run_blocks(PHASE_ITEMS + 40, 1'b1);
        drain_results();

        // no idling from here on
        send_idle_pct = 0;
        recv_idle_pct = 0;

        program_settings(5'($urandom_range(1, 20)), 32'($urandom_range(0, 500)),
                         32'($urandom_range(0, 500)), 31'($urandom_range(0, 1 << 20)),
                         31'($urandom_range(0, 1 << 16)), 16'($urandom_range(0, 100)),
                         8'($urandom_range(1, 10)));
        run_blocks(PHASE_ITEMS, 1'b0);
        drain_results();

        // a zero dead limit never alerts
        program_settings(5'd1, 32'd100, 32'd50, 31'($urandom),
                         31'($urandom_range(0, 2000)), 16'($urandom_range(0, 65535)), 8'd0);
        run_blocks(PHASE_ITEMS, 1'b0);
        drain_results();

        $display("summary: %0d samples, %0d block ends, %0d register settings, three idle mixes",
                 sb.samples_noted, sb.block_ends, settings_used);
        $display("summary: %0d dead alerts, %0d results with mic valid, %0d failures",
                 sb.alerts, sb.valid_results, sb.failures + sb.pending_results.size());
        if (sb.failures == 0 && sb.pending_results.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
